// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/smp_pkg.sv =====
// ----------------------------------------------------------------------------
// smp_pkg
// shared types and constants of the sha-256 message padder
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [3:0] LEN_HI_INDEX = 4'd14;
  localparam logic [3:0] LAST_INDEX   = 4'd15;
  localparam logic [5:0] LAST_POS     = 6'd55;

  // source of the word loaded into the output register
  typedef enum logic [2:0] {
    SEL_BYTE,
    SEL_FIRST,
    SEL_ZERO,
    SEL_LEN_HI,
    SEL_LEN_LO
  } word_sel_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic      take_byte;
    logic      emit;
    word_sel_t sel;
    logic      advance;
    logic      clear;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic slot_full;
    logic at_last_pos;
    logic next_is_len;
  } status_t;

endpackage

// ===== rtl/smp_datapath.sv =====
// ----------------------------------------------------------------------------
// smp_datapath
// bit count, block position, partial word and the output word register
// ----------------------------------------------------------------------------
module smp_datapath
  import smp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  data_byte,
  output status_t     status,
  output logic [31:0] out_word,
  output logic [3:0]  out_index,
  output logic        out_last,
  output logic        out_block_done
);

  logic [63:0] bit_length;
  logic [5:0]  block_position;
  logic [23:0] partial_word;
  logic [1:0]  slot;
  logic [3:0]  word_index;
  logic [31:0] first_word;
  logic [31:0] word_mux;

  assign slot       = block_position[1:0];
  assign word_index = block_position[5:2];

  // status for the controller
  assign status.slot_full   = (slot == 2'd3);
  assign status.at_last_pos = (block_position == LAST_POS);
  assign status.next_is_len = ((word_index + 4'd1) == LEN_HI_INDEX);

  // first padding word: pending bytes, the marker, then zeros
  always_comb begin
    case (slot)
      2'd0:    first_word = {PAD_MARK, 24'h000000};
      2'd1:    first_word = {partial_word[7:0], PAD_MARK, 16'h0000};
      2'd2:    first_word = {partial_word[15:0], PAD_MARK, 8'h00};
      default: first_word = {partial_word[23:0], PAD_MARK};
    endcase
  end

  // word source select
  always_comb begin
    case (cmd.sel)
      SEL_BYTE:   word_mux = {partial_word, data_byte};
      SEL_FIRST:  word_mux = first_word;
      SEL_ZERO:   word_mux = 32'h00000000;
      SEL_LEN_HI: word_mux = bit_length[63:32];
      SEL_LEN_LO: word_mux = bit_length[31:0];
      default:    word_mux = 32'h00000000;
    endcase
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length     <= 64'd0;
      block_position <= 6'd0;
      partial_word   <= 24'd0;
    end else if (cmd.clear) begin
      bit_length     <= 64'd0;
      block_position <= 6'd0;
      partial_word   <= 24'd0;
    end else if (cmd.take_byte) begin
      bit_length     <= bit_length + 64'd8;
      block_position <= block_position + 6'd1;
      partial_word   <= (slot == 2'd3) ? 24'd0 : {partial_word[15:0], data_byte};
    end else if (cmd.advance) begin
      block_position <= {word_index + 4'd1, 2'b00};
      partial_word   <= 24'd0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word  <= word_mux;
      out_index <= word_index;
      out_last  <= (cmd.sel == SEL_LEN_LO);
    end
  end

  assign out_block_done = (out_index == LAST_INDEX);

endmodule

// ===== rtl/smp_ctrl.sv =====
// ----------------------------------------------------------------------------
// smp_ctrl
// sequencer for byte intake and the padding run, owns the output valid flag
// ----------------------------------------------------------------------------
module smp_ctrl
  import smp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_has,
  input  logic    in_end,
  input  logic    out_ready,
  input  status_t status,
  output logic    in_ready,
  output logic    out_valid,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_BYTE,
    S_PAD_FIRST,
    S_PAD_ZERO,
    S_LEN_HI,
    S_LEN_LO
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  // output register can take a word when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_BYTE) && out_free;
  assign accept   = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    cmd.take_byte = 1'b0;
    cmd.emit      = 1'b0;
    cmd.sel       = SEL_BYTE;
    cmd.advance   = 1'b0;
    cmd.clear     = 1'b0;
    case (state)
      S_BYTE: begin
        if (accept && in_has) begin
          cmd.take_byte = 1'b1;
          cmd.emit      = status.slot_full;
        end
        // a byte landing at position 55 cancels the end flag
        if (accept && in_end && !(in_has && status.at_last_pos)) begin
          state_next = S_PAD_FIRST;
        end
      end
      S_PAD_FIRST: begin
        if (out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_FIRST;
          cmd.advance = 1'b1;
          state_next  = status.next_is_len ? S_LEN_HI : S_PAD_ZERO;
        end
      end
      S_PAD_ZERO: begin
        if (out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_ZERO;
          cmd.advance = 1'b1;
          if (status.next_is_len) begin
            state_next = S_LEN_HI;
          end
        end
      end
      S_LEN_HI: begin
        if (out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_LEN_HI;
          cmd.advance = 1'b1;
          state_next  = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_LEN_LO;
          cmd.clear  = 1'b1;
          state_next = S_BYTE;
        end
      end
      default: begin
        state_next = S_BYTE;
      end
    endcase
  end

  // state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BYTE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/sha256_message_padder.sv =====
// ----------------------------------------------------------------------------
// sha256_message_padder
// byte stream in, sha-256 padded stream out as big-endian 32-bit words
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the output side keeps up; every
// fourth byte yields one word transfer through the single output register.
// An item with the end flag starts the padding run: the 0x80 marker word,
// zero words and the two 32-bit halves of the 64-bit length, one word per cycle
// from the sequencer while the output side keeps up; no input is taken during
// the run. A byte carrying the end flag at block position 55 is appended and its
// end flag dropped; a following empty end item closes the message. After the
// final word (tlast) the state returns to reset for the next message.
`include "assert_macros.svh"

module sha256_message_padder
  import smp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte [7:0]
  input  logic        s_tuser,   // has_byte [0]
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // padded_word [31:0], word_in_block [35:32], zeros
  output logic        m_tuser,   // block_done [0]
  output logic        m_tlast    // message_done
);

  cmd_t        cmd;
  status_t     status;
  logic [31:0] out_word;
  logic [3:0]  out_index;
  logic        out_last;
  logic        out_block_done;

  // sequencer
  smp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_has    (s_tuser),
    .in_end    (s_tlast),
    .out_ready (m_tready),
    .status    (status),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  // message state and word assembly
  smp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .data_byte      (s_tdata),
    .status         (status),
    .out_word       (out_word),
    .out_index      (out_index),
    .out_last       (out_last),
    .out_block_done (out_block_done)
  );

  // output packing
  assign m_tdata = {4'b0000, out_index, out_word};
  assign m_tuser = out_block_done;
  assign m_tlast = out_last;

  // the final word always closes a block
  `ASSERT_SAME(a_last_ends_block, m_tvalid && m_tlast, m_tuser && (m_tdata[35:32] == LAST_INDEX))
  // no input is taken while a padding word is being produced
  `ASSERT_SAME(a_no_intake_in_pad, cmd.advance || cmd.clear, !s_tready)
  // the output register is empty after the final transfer
  `ASSERT_NEXT(a_ready_after_last, m_tvalid && m_tready && m_tlast, !m_tvalid)

endmodule
